[design/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Depends on nothing; the checker includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked only while the block is out of reset.
`define MBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property that is checked at every edge, reset included.
`define MBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mbs4_pkg.sv]
// Shared constants for the masked brush stamp block: defaults, field layout
// and configuration register indexes. Depends on nothing.
package mbs4_pkg;

  // Parameter defaults.
  localparam int MaxBrushDef     = 8;
  localparam int ScreenWidthDef  = 256;
  localparam int ScreenHeightDef = 192;

  // Field widths.
  localparam int CoordW   = 11;
  localparam int ColourW  = 4;
  localparam int SizeW    = 4;
  localparam int RaddrW   = 13;
  localparam int WordW    = 32;
  localparam int CountW   = 7;
  localparam int MaskW    = 64;
  localparam int OffsetW  = 10;

  // Input tdata layout, lowest bit first.
  localparam int InCxLo    = 0;
  localparam int InCyLo    = InCxLo + CoordW;
  localparam int InColLo   = InCyLo + CoordW;
  localparam int InSizeLo  = InColLo + ColourW;
  localparam int InRaddrLo = InSizeLo + SizeW;
  localparam int InTdataW  = 48;

  // Output tdata layout, lowest bit first.
  localparam int OutDataLo  = 0;
  localparam int OutCountLo = OutDataLo + WordW;
  localparam int OutTdataW  = 40;

  // Item kinds carried in tuser.
  localparam logic MODE_STAMP = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Configuration register indexes.
  localparam int CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] CFG_SHAPE_MASK = 1'd0;
  localparam logic [CfgIndexW-1:0] CFG_TOP_OFFSET = 1'd1;

endpackage

[design/mbs4_ram.sv]
// Generic single-clock RAM: one write port and one registered read port.
// A read in the same cycle as a write to that entry returns the old word.
module mbs4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6144,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array with a synchronous write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/masked_brush_stamp_4bpp_tiles.sv]
// Masked 4bpp brush stamp into a tiled pixel store, built around one RAM.
// Depends on mbs4_pkg and mbs4_ram.
//
// Usage: each input transaction on s_axis is either a stamp (tuser = 0) or
// a word read (tuser = 1), and yields exactly one output transaction on
// m_axis. A stamp walks the n x n square one cell per cycle, then enters
// the finish state, which loads its result into the output register once
// that register is free and returns to idle, where the next item is taken.
// A read passes through the read-wait state, which captures its word, and
// then finishes the same way; a zero-size stamp goes straight to finish.
// The walk is bound by the single read-modify-write path through the tile
// RAM: each cell reads its word, the next cycle merges the nibble and
// writes it back, overlapping the next cell's read, with a one-entry
// forward of the last written word. Items are handled one at a time; a new
// item is accepted while the last result still sits in the output register.
// After reset the block sweeps all MemWords words of the RAM to zero (6144
// with the defaults), one word per cycle; s_axis_tready stays low during
// the sweep. Configuration writes are taken at any time.
// When the receiver stalls, the finished result waits in the output
// register; the next item may still be accepted and worked, and its
// result holds back until the output register frees up.
module masked_brush_stamp_4bpp_tiles #(
  parameter int MAX_BRUSH     = mbs4_pkg::MaxBrushDef,
  parameter int SCREEN_WIDTH  = mbs4_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = mbs4_pkg::ScreenHeightDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [mbs4_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [mbs4_pkg::MaskW-1:0]         cfg_data_i,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: centre_x[10:0], centre_y[21:11], colour[25:22], brush_size[29:26],
  //        read_address[42:30], zero pad[47:43]
  input  logic [mbs4_pkg::InTdataW-1:0]      s_axis_tdata,
  // tuser: mode[0]
  input  logic                               s_axis_tuser,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: read_data[31:0], cells_painted[38:32], zero pad[39]
  output logic [mbs4_pkg::OutTdataW-1:0]     m_axis_tdata
);

  localparam int TilesAcross = SCREEN_WIDTH / 8;
  localparam int MemWords    = TilesAcross * ((SCREEN_HEIGHT + 7) / 8) * 8;
  localparam int AW          = (MemWords > 1) ? $clog2(MemWords) : 1;
  localparam int CW          = (MAX_BRUSH > 1) ? $clog2(MAX_BRUSH) : 1;
  localparam int PW          = 13;  // signed pixel coordinate width
  localparam int FullAW      = 19;  // unclipped word address width

  localparam logic signed [PW-1:0] ScrW = PW'(SCREEN_WIDTH);
  localparam logic signed [PW-1:0] ScrH = PW'(SCREEN_HEIGHT);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  // Input fields.
  logic signed [mbs4_pkg::CoordW-1:0] in_cx, in_cy;
  logic [mbs4_pkg::ColourW-1:0]       in_colour;
  logic [mbs4_pkg::SizeW-1:0]         in_size, in_size_sat;
  logic [mbs4_pkg::RaddrW-1:0]        in_raddr;
  logic [mbs4_pkg::SizeW-1:0]         in_half;

  assign in_cx     = s_axis_tdata[mbs4_pkg::InCxLo +: mbs4_pkg::CoordW];
  assign in_cy     = s_axis_tdata[mbs4_pkg::InCyLo +: mbs4_pkg::CoordW];
  assign in_colour = s_axis_tdata[mbs4_pkg::InColLo +: mbs4_pkg::ColourW];
  assign in_size   = s_axis_tdata[mbs4_pkg::InSizeLo +: mbs4_pkg::SizeW];
  assign in_raddr  = s_axis_tdata[mbs4_pkg::InRaddrLo +: mbs4_pkg::RaddrW];

  assign in_size_sat = (in_size > mbs4_pkg::SizeW'(MAX_BRUSH)) ?
                       mbs4_pkg::SizeW'(MAX_BRUSH) : in_size;
  assign in_half     = in_size_sat >> 1;

  // Control state.
  logic [2:0]                        state_q, state_d;
  logic [AW-1:0]                     clr_addr_q;
  logic [CW-1:0]                     col_q, row_q;
  logic [mbs4_pkg::CountW-1:0]       count_q;
  logic                              s1_valid_q;
  logic                              fwd_valid_q;
  logic                              m_valid_q;
  logic [mbs4_pkg::MaskW-1:0]        shape_mask_q;
  logic signed [mbs4_pkg::OffsetW-1:0] top_offset_q;

  // Item payload and pipeline data.
  logic signed [PW-1:0]              base_x_q, base_y_q, top_q;
  logic [mbs4_pkg::ColourW-1:0]      colour_q;
  logic [mbs4_pkg::SizeW-1:0]        size_q;
  logic                              rd_in_range_q;
  logic [AW-1:0]                     s1_addr_q;
  logic [2:0]                        s1_col_q;
  logic [AW-1:0]                     fwd_addr_q;
  logic [mbs4_pkg::WordW-1:0]        fwd_data_q;
  logic [mbs4_pkg::WordW-1:0]        res_data_q;
  logic [mbs4_pkg::OutTdataW-1:0]    m_data_q;

  logic accept, out_free;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Current cell of the walk.
  logic signed [PW-1:0]       cell_x, cell_y;
  logic                       x_ok, y_ok, mask_bit, addr_ok, cell_ok;
  logic [15:0]                tile_idx;
  logic [FullAW-1:0]          cell_addr;
  logic                       last_col, last_row;

  assign cell_x   = base_x_q + PW'(col_q);
  assign cell_y   = base_y_q + PW'(row_q);
  assign x_ok     = (cell_x >= 0) && (cell_x < ScrW);
  assign y_ok     = (cell_y >= 0) && (cell_y < ScrH) && (cell_y >= top_q);
  assign mask_bit = shape_mask_q[{3'(row_q), 3'(col_q)}];
  assign tile_idx = 16'(cell_x[PW-2:3]) + 16'(cell_y[PW-2:3]) * 16'(TilesAcross);
  assign cell_addr = FullAW'({tile_idx, cell_y[2:0]});
  assign addr_ok  = cell_addr < FullAW'(MemWords);
  assign cell_ok  = (state_q == S_WALK) && mask_bit && x_ok && y_ok && addr_ok;
  assign last_col = (mbs4_pkg::SizeW'(col_q) == size_q - mbs4_pkg::SizeW'(1));
  assign last_row = (mbs4_pkg::SizeW'(row_q) == size_q - mbs4_pkg::SizeW'(1));

  // RAM ports.
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [mbs4_pkg::WordW-1:0] ram_wdata, ram_rdata;
  logic [mbs4_pkg::WordW-1:0] merge_base, merge_word, nib_mask, nib_val;

  // Read address: the walk's cell, else the requested word of a read item.
  assign ram_raddr = (state_q == S_WALK) ? cell_addr[AW-1:0] : in_raddr[AW-1:0];

  // Merge one nibble into the word read last cycle, forwarding the previous
  // write when it hit the same entry.
  assign merge_base = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
  assign nib_mask   = mbs4_pkg::WordW'(4'hf) << {s1_col_q, 2'b00};
  assign nib_val    = mbs4_pkg::WordW'(colour_q) << {s1_col_q, 2'b00};
  assign merge_word = (merge_base & ~nib_mask) | nib_val;

  // Write port: the clearing sweep, else the merge stage.
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_q;
      ram_waddr = s1_addr_q;
      ram_wdata = merge_word;
    end
  end

  mbs4_ram #(
    .WIDTH(mbs4_pkg::WordW),
    .DEPTH(MemWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == AW'(MemWords - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == mbs4_pkg::MODE_READ) begin
            state_d = S_RDWAIT;
          end else if (in_size_sat == '0) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (last_col && last_row) state_d = S_FINISH;
      end
      S_RDWAIT: state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      col_q        <= '0;
      row_q        <= '0;
      count_q      <= '0;
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      m_valid_q    <= 1'b0;
      shape_mask_q <= '0;
      top_offset_q <= '0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= cell_ok;

      if (state_q == S_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end

      // Forward register tracks the last merge write of the current stamp.
      if (accept) begin
        fwd_valid_q <= 1'b0;
      end else if (s1_valid_q) begin
        fwd_valid_q <= 1'b1;
      end

      // Cell walk counters and paint count.
      if (accept) begin
        col_q   <= '0;
        row_q   <= '0;
        count_q <= '0;
      end else if (state_q == S_WALK) begin
        if (cell_ok) count_q <= count_q + mbs4_pkg::CountW'(1);
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + CW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end

      // Output register handshake.
      if ((state_q == S_FINISH) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // Configuration writes.
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mbs4_pkg::CFG_SHAPE_MASK: shape_mask_q <= cfg_data_i;
          mbs4_pkg::CFG_TOP_OFFSET: top_offset_q <= cfg_data_i[mbs4_pkg::OffsetW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_x_q      <= PW'(in_cx) - PW'(in_half);
      base_y_q      <= PW'(in_cy) - PW'(in_half);
      top_q         <= -ScrH - PW'(top_offset_q);
      colour_q      <= in_colour;
      size_q        <= in_size_sat;
      rd_in_range_q <= (14'(in_raddr) < 14'(MemWords));
      res_data_q    <= '0;
    end else if (state_q == S_RDWAIT) begin
      res_data_q <= rd_in_range_q ? ram_rdata : '0;
    end

    s1_addr_q <= cell_addr[AW-1:0];
    s1_col_q  <= cell_x[2:0];

    if (s1_valid_q) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= merge_word;
    end

    if ((state_q == S_FINISH) && out_free) begin
      m_data_q <= mbs4_pkg::OutTdataW'({count_q, res_data_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[design/mbs4_checker.sv]
// Port-level checks for the masked brush stamp block, bound to its top level.
// Depends on mbs4_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbs4_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mbs4_pkg::OutTdataW-1:0]  m_axis_tdata
);

  logic [mbs4_pkg::WordW-1:0]  out_word;
  logic [mbs4_pkg::CountW-1:0] out_count;

  assign out_word  = m_axis_tdata[mbs4_pkg::OutDataLo +: mbs4_pkg::WordW];
  assign out_count = m_axis_tdata[mbs4_pkg::OutCountLo +: mbs4_pkg::CountW];

  // A stalled result stays offered.
  `MBS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // A result is either a read word or a paint count, never both.
  `MBS_ASSERT(a_one_kind, clk_i, rst_ni, m_axis_tvalid |-> (out_word == '0 || out_count == '0), "result carries both a word and a count")

  // A stamp never paints more than the whole brush.
  `MBS_ASSERT(a_count_max, clk_i, rst_ni, m_axis_tvalid |-> out_count <= mbs4_pkg::CountW'(64), "paint count above 64")

  // Once reset has been seen at an edge, no input is taken and no result is shown.
  `MBS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready), "activity during reset")

endmodule

bind masked_brush_stamp_4bpp_tiles mbs4_checker u_mbs4_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[dv/masked_brush_stamp_4bpp_tiles_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the masked 4bpp brush stamp block: directed and random
// stamp and word-read transactions, checked against a scoreboard that keeps its own tile store.
// Depends on mbs4_pkg and the masked_brush_stamp_4bpp_tiles RTL.

localparam int TilesAcross = mbs4_pkg::ScreenWidthDef / 8;
localparam int TileRows    = (mbs4_pkg::ScreenHeightDef + 7) / 8;
localparam int StoreWords  = TilesAcross * TileRows * 8;

// One input transaction: the mode, then the tdata fields from the top down.
typedef struct packed {
  logic        mode;
  logic [12:0] raddr;
  logic [3:0]  size;
  logic [3:0]  colour;
  logic [10:0] cy;
  logic [10:0] cx;
} brush_item_t;

// One predicted output transaction.
typedef struct packed {
  logic [31:0] word;
  logic [6:0]  painted;
} stamp_result_t;

// Scoreboard: mirrors the tile store and the two registers, and queues the
// result that each accepted transaction should produce.
class stamp_scoreboard;
  bit [31:0]     tiles[StoreWords];
  bit [63:0]     shape;
  int            top_off;
  stamp_result_t awaited_q[$];
  int            errors;

  function void set_shape(bit [63:0] mask);
    shape = mask;
  endfunction

  function void set_top_offset(bit [9:0] value);
    top_off = $signed(value);
  endfunction

  function int pending();
    return awaited_q.size();
  endfunction

  // Work out the result of an accepted transaction and apply its writes.
  function void note_item(brush_item_t it);
    stamp_result_t r;
    int n, half, top, cxv, cyv, x, y, addr, painted;
    r = '0;
    if (it.mode == mbs4_pkg::MODE_READ) begin
      r.word = (int'(it.raddr) < StoreWords) ? tiles[it.raddr] : 32'h0;
    end else begin
      n = (int'(it.size) > mbs4_pkg::MaxBrushDef) ? mbs4_pkg::MaxBrushDef : int'(it.size);
      half = n / 2;
      top = -mbs4_pkg::ScreenHeightDef - top_off;
      cxv = $signed(it.cx);
      cyv = $signed(it.cy);
      painted = 0;
      for (int j = 0; j < n; j++) begin
        y = cyv - half + j;
        if (y < 0 || y >= mbs4_pkg::ScreenHeightDef || y < top) continue;
        for (int i = 0; i < n; i++) begin
          if (!shape[j * 8 + i]) continue;
          x = cxv - half + i;
          if (x < 0 || x >= mbs4_pkg::ScreenWidthDef) continue;
          addr = ((x / 8) + (y / 8) * TilesAcross) * 8 + (y % 8);
          if (addr >= StoreWords) continue;
          tiles[addr][4 * (x % 8) +: 4] = it.colour;
          painted++;
        end
      end
      r.painted = 7'(painted);
    end
    awaited_q.push_back(r);
  endfunction

  // Compare an output transaction with the oldest prediction.
  function void check_result(logic [mbs4_pkg::OutTdataW-1:0] tdata);
    stamp_result_t exp_r;
    if (awaited_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h with nothing outstanding", tdata);
      return;
    end
    exp_r = awaited_q.pop_front();
    if (tdata[31:0] !== exp_r.word || tdata[38:32] !== exp_r.painted) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: read_data exp %h got %h, cells_painted exp %0d got %0d",
                 exp_r.word, tdata[31:0], exp_r.painted, tdata[38:32]);
    end
  endfunction
endclass

module masked_brush_stamp_4bpp_tiles_tb;
  import mbs4_pkg::*;

  localparam int IdleLimit  = 20000;
  localparam int Phases     = 12;
  localparam int PhaseItems = 150;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgIndexW-1:0]  cfg_index_i   = CFG_SHAPE_MASK;
  logic [MaskW-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InTdataW-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tuser  = MODE_STAMP;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]  m_axis_tdata;

  stamp_scoreboard brush_sb;
  bit tx_steady, rx_steady;
  int rx_stall_left;
  int idle_cycles;
  int last_cx = 128;
  int last_cy = 96;

  masked_brush_stamp_4bpp_tiles u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Idle length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pixel_addr(int x, int y);
    return ((x / 8) + (y / 8) * TilesAcross) * 8 + (y % 8);
  endfunction

  function automatic brush_item_t stamp_item(int cx, int cy, int colour, int size);
    brush_item_t it;
    it.mode   = MODE_STAMP;
    it.raddr  = 13'($urandom);
    it.size   = 4'(size);
    it.colour = 4'(colour);
    it.cy     = 11'(cy);
    it.cx     = 11'(cx);
    return it;
  endfunction

  function automatic brush_item_t read_item(int addr);
    brush_item_t it;
    it        = brush_item_t'($urandom);
    it.mode   = MODE_READ;
    it.raddr  = 13'(addr);
    return it;
  endfunction

  // Output side: check every result transaction and stall tready at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) brush_sb.check_result(m_axis_tdata);
    if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 25) rx_stall_left = pick_gap();
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic issue(brush_item_t it);
    int gap;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 99) >= 55) gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {5'b0, it.raddr, it.size, it.colour, it.cy, it.cx};
    do @(posedge clk_i); while (!s_axis_tready);
    brush_sb.note_item(it);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (brush_sb.pending() > 0) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back edges; called during the clearing sweep and after each drain.
  task automatic load_config(bit [63:0] mask, bit [9:0] offset);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SHAPE_MASK;
    cfg_data_i  <= mask;
    @(posedge clk_i);
    brush_sb.set_shape(mask);
    cfg_index_i <= CFG_TOP_OFFSET;
    cfg_data_i  <= {54'b0, offset};
    @(posedge clk_i);
    brush_sb.set_top_offset(offset);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    brush_sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    load_config(64'hFFFF_FFFF_FFFF_FFFF, 10'd0);

    // Directed part: corners, clipping, oversized and zero brushes, reads past the store.
    issue(read_item(0));
    issue(stamp_item(0, 0, 15, 8));
    issue(read_item(0));
    issue(stamp_item(255, 191, 10, 15));
    issue(read_item(StoreWords - 1));
    issue(read_item(StoreWords));
    issue(read_item(8191));
    issue(stamp_item(100, 100, 7, 0));
    issue(stamp_item(-1024, -1024, 5, 8));
    issue(stamp_item(1023, 1023, 5, 8));
    // Repainting with the same colour still counts every cell.
    issue(stamp_item(0, 0, 15, 8));
    issue(stamp_item(10, 10, 3, 1));
    issue(read_item(pixel_addr(10, 10)));
    issue(stamp_item(128, 96, 9, 7));
    issue(read_item(pixel_addr(128, 96)));
    // Most negative offset pushes the top bound below the whole screen.
    drain();
    load_config(64'h8142_2418_1824_4281, 10'h200);
    issue(stamp_item(100, 100, 12, 8));
    // A top bound inside the screen cuts the upper rows of the brush.
    drain();
    load_config(64'hAA55_AA55_AA55_AA55, 10'(-300));
    issue(stamp_item(50, 108, 6, 8));
    issue(read_item(pixel_addr(50, 108)));
    issue(read_item(pixel_addr(50, 110)));
    drain();
    load_config(64'h0, 10'h1FF);
    issue(stamp_item(60, 60, 1, 8));

    // Random part: one register setting per phase.
    for (int p = 0; p < Phases; p++) begin
      bit [63:0] mask;
      bit [9:0]  offset;
      drain();
      case ($urandom_range(0, 7))
        0:       mask = 64'hFFFF_FFFF_FFFF_FFFF;
        1:       mask = 64'h0000_0000_0000_0001;
        2:       mask = 64'h8000_0000_0000_0000;
        3:       mask = {$urandom, $urandom} & {$urandom, $urandom};
        4:       mask = {$urandom, $urandom} | {$urandom, $urandom};
        default: mask = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
        0, 1:    offset = 10'd0;
        2:       offset = 10'h200;
        3:       offset = 10'h1FF;
        4:       offset = 10'(-int'($urandom_range(193, 400)));
        default: offset = 10'($urandom);
      endcase
      if (p == Phases - 1) mask = 64'hFFFF_FFFF_FFFF_FFFF;
      load_config(mask, offset);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PhaseItems; k++) begin
        brush_item_t it;
        int sel, cx, cy, size;
        sel = $urandom_range(0, 99);
        if (sel < 78) begin
          if ($urandom_range(0, 9) == 0) begin
            cx = $signed(11'($urandom));
            cy = $signed(11'($urandom));
          end else begin
            cx = int'($urandom_range(0, 271)) - 8;
            cy = int'($urandom_range(0, 207)) - 8;
            last_cx = cx;
            last_cy = cy;
          end
          case ($urandom_range(0, 9))
            0:       size = 0;
            1:       size = $urandom_range(9, 15);
            2, 3:    size = 8;
            default: size = $urandom_range(1, 8);
          endcase
          it = stamp_item(cx, cy, $urandom_range(0, 15), size);
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 50) begin
            // Read back a word near the most recent on-screen stamp.
            cx = last_cx + int'($urandom_range(0, 8)) - 4;
            cy = last_cy + int'($urandom_range(0, 8)) - 4;
            cx = (cx < 0) ? 0 : ((cx > ScreenWidthDef - 1) ? ScreenWidthDef - 1 : cx);
            cy = (cy < 0) ? 0 : ((cy > ScreenHeightDef - 1) ? ScreenHeightDef - 1 : cy);
            it = read_item(pixel_addr(cx, cy));
          end else if (sel < 85) begin
            it = read_item($urandom_range(0, StoreWords - 1));
          end else begin
            it = read_item($urandom_range(StoreWords, 8191));
          end
        end
        issue(it);
      end
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (brush_sb.errors == 0 && brush_sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
